// ===== rtl/core/vha_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the vector heading angle block.
// Depends on nothing; used by every module under rtl/core.
package vha_pkg;

	localparam int VEC_SCALE  = 24;
	localparam int ANGLE_FRAC = 18;
	localparam int Z_W        = 29;
	localparam int OUT_SHIFT  = 12;
	localparam int TABLE_LEN  = 24;
	localparam int IDX_W      = 5;
	localparam int OUT_W      = 15;
	localparam int R_W        = 16;

	typedef logic signed [Z_W-1:0] angle_t;

	localparam angle_t DEG180   = angle_t'(180) <<< ANGLE_FRAC;
	localparam angle_t DEG360   = angle_t'(360) <<< ANGLE_FRAC;
	localparam angle_t ROUND_HALF = angle_t'(1) <<< (OUT_SHIFT - 1);

	localparam logic [R_W-1:0]   FULL_TURN    = R_W'(23040);
	localparam logic [OUT_W-1:0] ZERO_HEADING = OUT_W'(5760);

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	function automatic angle_t atan_entry(input logic [IDX_W-1:0] idx);
		angle_t a;
		a = '0;
		case (idx)
			5'd0:  a = angle_t'(11796480);
			5'd1:  a = angle_t'(6963869);
			5'd2:  a = angle_t'(3679517);
			5'd3:  a = angle_t'(1867780);
			5'd4:  a = angle_t'(937515);
			5'd5:  a = angle_t'(469214);
			5'd6:  a = angle_t'(234664);
			5'd7:  a = angle_t'(117339);
			5'd8:  a = angle_t'(58671);
			5'd9:  a = angle_t'(29335);
			5'd10: a = angle_t'(14668);
			5'd11: a = angle_t'(7334);
			5'd12: a = angle_t'(3667);
			5'd13: a = angle_t'(1833);
			5'd14: a = angle_t'(917);
			5'd15: a = angle_t'(458);
			5'd16: a = angle_t'(229);
			5'd17: a = angle_t'(115);
			5'd18: a = angle_t'(57);
			5'd19: a = angle_t'(29);
			5'd20: a = angle_t'(14);
			5'd21: a = angle_t'(7);
			5'd22: a = angle_t'(4);
			5'd23: a = angle_t'(2);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/vha_front.sv =====
`timescale 1ns / 1ps
// First pipeline stage: difference vector, fold into the right half plane, scaling.
// Depends on vha_pkg.
module vha_front #(
	parameter int COORD_WIDTH = 16,
	parameter int XY_W        = 44
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	output vha_pkg::ctl_t                 ctl,
	output logic signed [XY_W-1:0]        x,
	output logic signed [XY_W-1:0]        y,
	output vha_pkg::angle_t               z
);

	logic signed [COORD_WIDTH:0] dx, dy, fx, fy;
	logic                        neg;
	vha_pkg::ctl_t               ctl_s1;
	logic signed [XY_W-1:0]      x_s1, y_s1;
	vha_pkg::angle_t             z_s1;

	always_comb begin
		dx  = (COORD_WIDTH+1)'(first_x) - (COORD_WIDTH+1)'(second_x);
		dy  = (COORD_WIDTH+1)'(first_y) - (COORD_WIDTH+1)'(second_y);
		neg = dx[COORD_WIDTH];
		fx  = neg ? -dx : dx;
		fy  = neg ? -dy : dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= take;
			ctl_s1.zero  <= (dx == '0) && (dy == '0);
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= XY_W'(fx) <<< vha_pkg::VEC_SCALE;
		y_s1 <= XY_W'(fy) <<< vha_pkg::VEC_SCALE;
		z_s1 <= neg ? vha_pkg::DEG180 : '0;
	end

	assign ctl = ctl_s1;
	assign x   = x_s1;
	assign y   = y_s1;
	assign z   = z_s1;

endmodule

// ===== rtl/core/vha_cordic_stage.sv =====
`timescale 1ns / 1ps
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// Depends on vha_pkg for the angle type and the arctangent table.
module vha_cordic_stage #(
	parameter int XY_W = 44,
	parameter int STEP = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vha_pkg::ctl_t          ctl_in,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	input  vha_pkg::angle_t        z_in,
	output vha_pkg::ctl_t          ctl_out,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [XY_W-1:0] y_out,
	output vha_pkg::angle_t        z_out
);

	localparam vha_pkg::angle_t ATAN = vha_pkg::atan_entry(vha_pkg::IDX_W'(STEP));

	logic signed [XY_W-1:0] sx, sy, nx, ny;
	vha_pkg::angle_t        nz;
	vha_pkg::ctl_t          ctl_s1;
	logic signed [XY_W-1:0] x_s1, y_s1;
	vha_pkg::angle_t        z_s1;

	always_comb begin
		sx = x_in >>> STEP;
		sy = y_in >>> STEP;
		if (!y_in[XY_W-1]) begin
			nx = x_in + sy;
			ny = y_in - sx;
			nz = z_in + ATAN;
		end else begin
			nx = x_in - sy;
			ny = y_in + sx;
			nz = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= nx;
		y_s1 <= ny;
		z_s1 <= nz;
	end

	assign ctl_out = ctl_s1;
	assign x_out   = x_s1;
	assign y_out   = y_s1;
	assign z_out   = z_s1;

endmodule

// ===== rtl/core/vha_back.sv =====
`timescale 1ns / 1ps
// Last pipeline stage: rounds the angle to 1/64 degree and wraps it into one turn.
// Depends on vha_pkg.
module vha_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vha_pkg::ctl_t                     ctl_in,
	input  vha_pkg::angle_t                   z_in,
	output logic                              done,
	output logic [vha_pkg::OUT_W-1:0]         heading
);

	vha_pkg::angle_t            zs;
	logic [vha_pkg::R_W-1:0]    r, w;
	logic                       valid_s1;
	logic [vha_pkg::OUT_W-1:0]  heading_s1;

	always_comb begin
		zs = z_in + vha_pkg::DEG360 + vha_pkg::ROUND_HALF;
		r  = zs[vha_pkg::OUT_SHIFT +: vha_pkg::R_W];
		w  = (r >= vha_pkg::FULL_TURN) ? r - vha_pkg::FULL_TURN : r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		heading_s1 <= ctl_in.zero ? vha_pkg::ZERO_HEADING : w[vha_pkg::OUT_W-1:0];
	end

	assign done    = valid_s1;
	assign heading = heading_s1;

endmodule

// ===== rtl/core/vector_heading_angle.sv =====
`timescale 1ns / 1ps
// Heading of the vector from a second point to a first point, in 1/64 degree.
// Depends on vha_pkg, vha_front, vha_cordic_stage and vha_back.
//
// Usage:
// A transfer into the block happens at a rising edge with start high and busy
// low. The block never raises busy, so a new pair of points may be given in
// every cycle. Each transfer yields one heading, 0 to 23039, counterclockwise
// from the +x axis; a zero vector gives 90 degrees (5760).
// The result is on heading for exactly one cycle while done is high, and is
// taken at the edge that ends that cycle; the receiver cannot hold it off.
// Between the transfer and done, one stage forms and folds the difference
// vector, one stage per micro-rotation follows, and a final stage rounds and
// wraps the angle.
// Throughput is one item per cycle, set by the fully unrolled rotation chain.
// Reset clears every valid bit at once, so nothing in flight is delivered;
// the block is ready as soon as reset is released.
module vector_heading_angle #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_WIDTH  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_WIDTH-1:0]     first_x,
	input  logic signed [COORD_WIDTH-1:0]     first_y,
	input  logic signed [COORD_WIDTH-1:0]     second_x,
	input  logic signed [COORD_WIDTH-1:0]     second_y,
	output logic                              done,
	output logic [vha_pkg::OUT_W-1:0]         heading
);

	localparam int XY_W    = COORD_WIDTH + vha_pkg::VEC_SCALE + 4;
	localparam int LATENCY = CORDIC_STEPS + 2;

	vha_pkg::ctl_t          ctl_p [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] x_p   [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_p   [CORDIC_STEPS+1];
	vha_pkg::angle_t        z_p   [CORDIC_STEPS+1];

	assign busy = 1'b0;

	vha_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.XY_W       (XY_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (start && !busy),
		.first_x (first_x),
		.first_y (first_y),
		.second_x(second_x),
		.second_y(second_y),
		.ctl     (ctl_p[0]),
		.x       (x_p[0]),
		.y       (y_p[0]),
		.z       (z_p[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		vha_cordic_stage #(
			.XY_W(XY_W),
			.STEP(i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_p[i]),
			.x_in   (x_p[i]),
			.y_in   (y_p[i]),
			.z_in   (z_p[i]),
			.ctl_out(ctl_p[i+1]),
			.x_out  (x_p[i+1]),
			.y_out  (y_p[i+1]),
			.z_out  (z_p[i+1])
		);
	end

	vha_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_p[CORDIC_STEPS]),
		.z_in   (z_p[CORDIC_STEPS]),
		.done   (done),
		.heading(heading)
	);

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("Result strobe without a transfer in at the pipeline latency.");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading < vha_pkg::OUT_W'(23040)))
		else $error("Heading lies outside one full turn.");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && first_x == second_x && first_y == second_y)
		|-> ##LATENCY (done && heading == vha_pkg::ZERO_HEADING))
		else $error("Zero vector did not give a heading of ninety degrees.");
`endif

endmodule
